[hdl/aes256_ctr_cipher_defines.svh]
// assertion macros for the aes-256 ctr block
`ifndef AES256_CTR_CIPHER_DEFINES_SVH
`define AES256_CTR_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, prop)
`endif
`endif

[hdl/aesctr_pkg.sv]
package aesctr_pkg;

  localparam int unsigned NumRounds = 14;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // latch input item, start key schedule and round 0
    logic do_round;  // run one cipher round
    logic last;      // current round is the final one (no mix columns)
    logic finish;    // form result, advance counter
  } aesctr_cmd_t;

  // aes s-box
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return s[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

[hdl/aesctr_ctrl.sv]
module aesctr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     out_valid_i,
  input  logic                     out_ready,
  output aesctr_pkg::aesctr_cmd_t  cmd_o,
  output logic                     busy_o
);
  import aesctr_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRound = 3'b010,
    StDone  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] round_q, round_d;

  // output register may hold one result while the next item runs
  assign in_ready = (state_q == StIdle);
  assign busy_o   = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid && in_ready) begin
          cmd_o.load = 1'b1;
          round_d    = 4'd1;
          state_d    = StRound;
        end
      end
      StRound: begin
        cmd_o.do_round = 1'b1;
        cmd_o.last     = (round_q == 4'(NumRounds));
        if (round_q == 4'(NumRounds)) begin
          state_d = StDone;
        end else begin
          round_d = round_q + 4'd1;
        end
      end
      StDone: begin
        // wait for the output register to free up
        if (!out_valid_i || out_ready) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

endmodule

[hdl/aesctr_datapath.sv]
module aesctr_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aesctr_pkg::aesctr_cmd_t cmd_i,
  input  logic [255:0]            key_i,
  input  logic [127:0]            iv_i,
  input  logic [63:0]             data_high_i,
  input  logic [63:0]             data_low_i,
  input  logic [4:0]              byte_count_i,
  input  logic                    message_start_i,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [63:0]             out_high_o,
  output logic [63:0]             out_low_o,
  output logic [4:0]              out_count_o
);
  import aesctr_pkg::*;

  logic [127:0] ctr_q, ctr_d;
  logic [127:0] state_q, state_d;
  logic [127:0] data_q;
  logic [4:0]   count_q;
  // rolling key window: eight schedule words, advanced four words per round
  logic [255:0] kwin_q, kwin_d;
  logic [7:0]   rcon_q, rcon_d;
  logic         half_q, half_d;
  logic         out_valid_q;
  logic [127:0] res_q;
  logic [4:0]   ocount_q;

  // counter chosen for this item
  logic [127:0] ctr_use;
  assign ctr_use = message_start_i ? iv_i : ctr_q;

  // one aes round on the state, with the current round key
  logic [7:0]   sb  [16];
  logic [7:0]   mx  [16];
  logic [127:0] sr_flat, mix_flat, rk;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = sbox(state_q[127 - 8*(((c+r)%4)*4+r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      mx[c*4+0] = xtime(sb[c*4]) ^ xtime(sb[c*4+1]) ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3];
      mx[c*4+1] = sb[c*4] ^ xtime(sb[c*4+1]) ^ xtime(sb[c*4+2]) ^ sb[c*4+2] ^ sb[c*4+3];
      mx[c*4+2] = sb[c*4] ^ sb[c*4+1] ^ xtime(sb[c*4+2]) ^ xtime(sb[c*4+3]) ^ sb[c*4+3];
      mx[c*4+3] = xtime(sb[c*4]) ^ sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ xtime(sb[c*4+3]);
    end
    for (int j = 0; j < 16; j++) begin
      sr_flat[127 - 8*j -: 8]  = sb[j];
      mix_flat[127 - 8*j -: 8] = mx[j];
    end
  end

  // round key: always the newest four words, the lower half of the window
  assign rk = kwin_q[127:0];

  // next four schedule words, alternating rotword+rcon and plain subword
  logic [31:0] t, w0, w1, w2, w3;
  always_comb begin
    if (half_q) t = sub_word({kwin_q[23:0], kwin_q[31:24]}) ^ {rcon_q, 24'h0};
    else        t = sub_word(kwin_q[31:0]);
    w0 = kwin_q[255:224] ^ t;
    w1 = kwin_q[223:192] ^ w0;
    w2 = kwin_q[191:160] ^ w1;
    w3 = kwin_q[159:128] ^ w2;
  end

  // result bytes masked above the count
  logic [127:0] ks, mask;
  assign ks = state_q;
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      mask[127 - 8*j -: 8] = (5'(j) < count_q) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    kwin_d  = kwin_q;
    rcon_d  = rcon_q;
    half_d  = half_q;
    if (cmd_i.load) begin
      state_d = ctr_use ^ key_i[255:128];
      kwin_d  = key_i;
      rcon_d  = 8'h01;
      half_d  = 1'b1;
    end else if (cmd_i.do_round) begin
      state_d = (cmd_i.last ? sr_flat : mix_flat) ^ rk;
      half_d  = !half_q;
      kwin_d  = {kwin_q[127:0], w0, w1, w2, w3};
      if (half_q) begin
        rcon_d = xtime(rcon_q);
      end
    end
  end

  assign ctr_d = ctr_use;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) ctr_q <= ctr_d;
      else if (cmd_i.finish) ctr_q <= ctr_q + 128'd1;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    kwin_q  <= kwin_d;
    rcon_q  <= rcon_d;
    half_q  <= half_d;
    if (cmd_i.load) begin
      data_q  <= {data_high_i, data_low_i};
      count_q <= byte_count_i;
    end
    if (cmd_i.finish) begin
      res_q    <= (data_q ^ ks) & mask;
      ocount_q <= count_q;
    end
  end

  assign out_valid   = out_valid_q;
  assign out_high_o  = res_q[127:64];
  assign out_low_o   = res_q[63:0];
  assign out_count_o = ocount_q;

endmodule

[hdl/aes256_ctr_cipher.sv]
// aes-256 counter mode, one 16-byte beat in, one beat out. the initial key
// addition happens at the accept edge, then fourteen rounds run through a
// single round unit with the key schedule computed on the fly, then the result
// is written to the output register. a new item is accepted only once the
// previous result has been written to the output register, not while one is
// in its rounds; a stalled receiver holds the next item in the done state,
// after its last round, until the output register frees up.
// message_start reloads the counter from the iv registers; the counter
// advances by one after every item and wraps at 128 bits.
`include "aes256_ctr_cipher_defines.svh"
module aes256_ctr_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic [4:0]  byte_count_i,
  input  logic        message_start_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic [4:0]  out_count_o
);
  import aesctr_pkg::*;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegIvHi = 3'd4;
  localparam logic [2:0] RegIvLo = 3'd5;

  logic [255:0] key_q;
  logic [127:0] iv_q;
  aesctr_cmd_t  cmd;
  logic         busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKey0: key_q[255:192] <= cfg_data_i;
        RegKey1: key_q[191:128] <= cfg_data_i;
        RegKey2: key_q[127:64]  <= cfg_data_i;
        RegKey3: key_q[63:0]    <= cfg_data_i;
        RegIvHi: iv_q[127:64]   <= cfg_data_i;
        RegIvLo: iv_q[63:0]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aesctr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .out_valid_i(out_valid), .out_ready,
    .cmd_o(cmd), .busy_o(busy)
  );

  aesctr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .key_i(key_q), .iv_i(iv_q),
    .data_high_i, .data_low_i, .byte_count_i, .message_start_i,
    .out_ready, .out_valid, .out_high_o, .out_low_o, .out_count_o
  );

  `ASSERT_NEVER(a_no_accept_busy, in_valid && in_ready && busy)
  `ASSERT_IMPL(a_load_then_round, cmd.load |=> cmd.do_round)
  `ASSERT_IMPL(a_finish_valid, cmd.finish |=> out_valid)
  `ASSERT_NEVER(a_cmd_overlap, cmd.load && (cmd.do_round || cmd.finish))

endmodule

[bench/aes256_ctr_cipher_tb.sv]
`timescale 1ns / 1ps
module aes256_ctr_cipher_tb;

  localparam logic [2:0] RegKey0  = 3'd0;
  localparam logic [2:0] RegKey1  = 3'd1;
  localparam logic [2:0] RegKey2  = 3'd2;
  localparam logic [2:0] RegKey3  = 3'd3;
  localparam logic [2:0] RegIvHigh = 3'd4;
  localparam logic [2:0] RegIvLow  = 3'd5;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 20000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
  } cipher_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        start;
    logic        known;
    cipher_beat_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] data_high_i = '0;
  logic [63:0] data_low_i = '0;
  logic [4:0]  byte_count_i = '0;
  logic        message_start_i = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;
  logic [4:0]  out_count_o;

  aes256_ctr_cipher dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_hi_reg, iv_lo_reg;
  logic [127:0] ctr_value;
  cipher_beat_t cipher_expected [$];

  int unsigned fail_count = 0;
  int unsigned beats_in = 0, beats_out = 0, idle_cycles = 0;
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  bit          hold_recv = 1'b0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-box from field inverse plus affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] r, b;
    r = 8'h01;
    b = x;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
           ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_word32(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  // one keystream block: aes-256 encryption of the counter
  function automatic logic [127:0] keystream(input logic [127:0] ctr);
    logic [31:0] w [60];
    logic [7:0]  st [16];
    logic [7:0]  t [16];
    logic [31:0] tmp;
    logic [7:0]  a, b, c, d;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_reg[i][63:32];
      w[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      tmp = w[i-1];
      if (i % 8 == 0) tmp = sub_word32({tmp[23:0], tmp[31:24]}) ^ ((32'h1 << (i/8 - 1)) << 24);
      else if (i % 8 == 4) tmp = sub_word32(tmp);
      w[i] = w[i-8] ^ tmp;
    end
    for (int j = 0; j < 16; j++) st[j] = ctr[127-8*j -: 8];
    for (int r = 0; r <= 14; r++) begin
      if (r > 0) begin
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++)
            t[cc*4+rr] = sub_byte(st[((cc + rr) & 3)*4 + rr]);
        if (r < 14) begin
          for (int cc = 0; cc < 4; cc++) begin
            a = t[cc*4]; b = t[cc*4+1]; c = t[cc*4+2]; d = t[cc*4+3];
            t[cc*4]   = gmul(a, 2) ^ gmul(b, 3) ^ c ^ d;
            t[cc*4+1] = a ^ gmul(b, 2) ^ gmul(c, 3) ^ d;
            t[cc*4+2] = a ^ b ^ gmul(c, 2) ^ gmul(d, 3);
            t[cc*4+3] = gmul(a, 3) ^ b ^ c ^ gmul(d, 2);
          end
        end
        st = t;
      end
      for (int cc = 0; cc < 4; cc++)
        for (int k = 0; k < 4; k++)
          st[cc*4+k] ^= w[r*4+cc][31-8*k -: 8];
    end
    tmp = 0;
    keystream = '0;
    for (int j = 0; j < 16; j++) keystream[127-8*j -: 8] = st[j];
  endfunction

  // expected ciphertext beat for one accepted data beat
  function automatic cipher_beat_t encrypt_beat(input logic [63:0] hi, input logic [63:0] lo,
                                                input logic [4:0] cnt, input logic start);
    logic [127:0] ks, data, res;
    int unsigned  nvalid;
    cipher_beat_t r;
    if (start) ctr_value = {iv_hi_reg, iv_lo_reg};
    ks = keystream(ctr_value);
    data = {hi, lo};
    nvalid = (cnt > 16) ? 16 : cnt;
    res = '0;
    for (int j = 0; j < 16; j++)
      if (j < nvalid) res[127-8*j -: 8] = data[127-8*j -: 8] ^ ks[127-8*j -: 8];
    ctr_value = ctr_value + 128'd1;
    r.hi = res[127:64];
    r.lo = res[63:0];
    r.cnt = cnt;
    return r;
  endfunction

  // one register write; the enable is dropped by the caller after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegKey0:   key_reg[0] = val;
      RegKey1:   key_reg[1] = val;
      RegKey2:   key_reg[2] = val;
      RegKey3:   key_reg[3] = val;
      RegIvHigh: iv_hi_reg = val;
      RegIvLow:  iv_lo_reg = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // offer one beat; valid stays up until the caller goes idle or sends again
  task automatic send_beat(input logic [63:0] hi, input logic [63:0] lo,
                           input logic [4:0] cnt, input logic start);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_high_i <= hi;
    data_low_i <= lo;
    byte_count_i <= cnt;
    message_start_i <= start;
    do @(posedge clk_i); while (!in_ready);
    cipher_expected.push_back(encrypt_beat(hi, lo, cnt, start));
    beats_in++;
  endtask

  task automatic write_all_regs(input logic [63:0] v [6]);
    for (int i = 0; i < 6; i++) write_reg(3'(i), v[i]);
    cfg_we_i <= 1'b0;
  endtask

  // receiver ready
  always @(posedge clk_i) begin
    if (hold_recv) out_ready <= 1'b0;
    else out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    cipher_beat_t w;
    if (rst_ni && out_valid && out_ready) begin
      beats_out++;
      if (cipher_expected.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        w = cipher_expected.pop_front();
        if (out_high_o !== w.hi) begin
          $error("out_high expected %h got %h", w.hi, out_high_o); fail_count++;
        end
        if (out_low_o !== w.lo) begin
          $error("out_low expected %h got %h", w.lo, out_low_o); fail_count++;
        end
        if (out_count_o !== w.cnt) begin
          $error("out_count expected %0d got %0d", w.cnt, out_count_o); fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // directed rows; results typed in only for fully masked beats
  stim_row_t dir_rows [$];

  function automatic stim_row_t mk(input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [4:0] cnt, input logic start, input logic known);
    stim_row_t r;
    r.hi = hi; r.lo = lo; r.cnt = cnt; r.start = start; r.known = known;
    r.want = '{hi: 64'h0, lo: 64'h0, cnt: cnt};
    return r;
  endfunction

  initial begin
    logic [63:0] regs [6];
    cipher_beat_t got;
    int unsigned n;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    iv_hi_reg = '0; iv_lo_reg = '0; ctr_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: no start after reset, counts 0/1/8/9/15/16/17/31, all ones and zeros
    dir_rows.push_back(mk(64'h0, 64'h0, 5'd16, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd16, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd0, 1'b0, 1'b1));
    dir_rows.push_back(mk(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1, 1'b1, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd8, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd9, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd15, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd17, 1'b0, 1'b0));
    dir_rows.push_back(mk('1, '1, 5'd31, 1'b1, 1'b0));
    dir_rows.push_back(mk(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd16, 1'b0, 1'b0));
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].cnt, dir_rows[i].start);
      if (dir_rows[i].known) begin
        got = cipher_expected[$];
        if (got !== dir_rows[i].want) begin
          $error("masked row %0d expected %h got %h", i, dir_rows[i].want, got);
          fail_count++;
        end
      end
    end
    wait_drained();

    // fips-197 style key and a counter about to wrap, also all-ones key
    regs = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f, '1, 64'hfffffffffffffffe};
    write_all_regs(regs);
    for (int i = 0; i < 5; i++) send_beat($urandom, {$urandom, $urandom}, 5'd16, i == 0);
    wait_drained();
    regs = '{'1, '1, '1, '1, 64'h0, '1};
    write_all_regs(regs);
    for (int i = 0; i < 4; i++) send_beat('1, '0, 5'(i * 5), i == 0);
    wait_drained();

    // random phases with different idling and a fresh key each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        3: begin send_idle_pct = 32; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 6; i++) regs[i] = {$urandom, $urandom};
      write_all_regs(regs);
      if (ph == 4) begin
        // long receiver hold-off while beats keep coming
        fork
          begin
            hold_recv = 1'b1;
            repeat (600) @(posedge clk_i);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 200; i++) begin
        n = $urandom_range(99);
        send_beat({$urandom, $urandom}, {$urandom, $urandom},
                  n < 70 ? 5'd16 : 5'($urandom_range(31)),
                  i == 0 || $urandom_range(19) == 0);
        // sender waits out all pending results once per phase
        if (i == 100) begin
          in_valid <= 1'b0;
          while (cipher_expected.size() != 0) @(posedge clk_i);
        end
      end
      wait_drained();
    end

    $display("covered %0d beats in, %0d out, over 8 key settings and idling mixes",
             beats_in, beats_out);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/aesctr_pkg.sv
hdl/aesctr_ctrl.sv
hdl/aesctr_datapath.sv
hdl/aes256_ctr_cipher.sv
bench/aes256_ctr_cipher_tb.sv
